// File: sv/min_stk_pkg.sv
// ----------------------------------------------------------------------------
// min_stk_pkg
// Shared types and codes for the minimum-tracking stack.
// ----------------------------------------------------------------------------
`default_nettype none

package min_stk_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // Request codes carried on req_type.
  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_MIN  = 2'd2;

  // Status codes reported with each result.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request and read the top entry
    logic exec;     // apply the request and load the result register
  } cmd_t;

endpackage : min_stk_pkg

`default_nettype wire

// File: sv/min_stk_ctrl.sv
// ----------------------------------------------------------------------------
// min_stk_ctrl
// Controller: sequences capture, execute and result hand-off per request.
// ----------------------------------------------------------------------------
`default_nettype none

module min_stk_ctrl
  import min_stk_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic out_stall,
  output logic in_stall,
  output logic out_valid,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule : min_stk_ctrl

`default_nettype wire

// File: sv/min_stk_dp.sv
// ----------------------------------------------------------------------------
// min_stk_dp
// Datapath: value and running-minimum memories, entry count, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module min_stk_dp
  import min_stk_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW          = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  input  logic [1:0]             req_type,
  input  logic [VALUE_WIDTH-1:0] push_value,
  output logic [VALUE_WIDTH-1:0] result_value,
  output logic [1:0]             status,
  output logic [CW-1:0]          fill_count
);

  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [VALUE_WIDTH-1:0] value_mem [DEPTH];
  logic [VALUE_WIDTH-1:0] min_mem   [DEPTH];

  logic [1:0]             req;
  logic [VALUE_WIDTH-1:0] val;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [VALUE_WIDTH-1:0] rd_min;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;

  logic [AW-1:0]          top_addr;
  logic [AW-1:0]          wr_addr;
  logic                   is_empty;
  logic                   is_full;
  logic                   do_push;
  logic [VALUE_WIDTH-1:0] new_min;
  logic [VALUE_WIDTH-1:0] result_next;
  logic [1:0]             status_next;

  // The top entry sits one below the count; on an empty stack the read is
  // discarded.
  assign top_addr = AW'(count - CW'(1));
  assign wr_addr  = AW'(count);
  assign is_empty = (count == '0);
  assign is_full  = (count >= FULL_COUNT);
  assign do_push  = cmd.exec && (req == REQ_PUSH) && !is_full;

  // The new running minimum keeps the one below unless the pushed value is
  // strictly smaller.
  always_comb begin
    new_min = val;
    if (!is_empty && ($signed(rd_min) < $signed(val))) begin
      new_min = rd_min;
    end
  end

  always_comb begin
    result_next = '0;
    status_next = ST_OK;
    count_next  = count;
    case (req)
      REQ_PUSH: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      REQ_POP: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          result_next = rd_val;
          count_next  = count - CW'(1);
        end
      end
      REQ_MIN: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          result_next = rd_min;
        end
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_val <= value_mem[top_addr];
      rd_min <= min_mem[top_addr];
    end
    if (do_push) begin
      value_mem[wr_addr] <= val;
      min_mem[wr_addr]   <= new_min;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= req_type;
      val <= push_value;
    end
    if (cmd.exec) begin
      result_value <= result_next;
      status       <= status_next;
      fill_count   <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

endmodule : min_stk_dp

`default_nettype wire

// File: sv/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// min_tracking_stack
// LIFO stack of signed values that also reports its current minimum.
// ----------------------------------------------------------------------------
// Usage:
// A request (req_type, push_value) is taken on in_valid when in_stall is low.
// req_type selects push, pop or minimum query. Every request returns exactly
// one result (result_value, status, fill_count) on out_valid, taken when
// out_stall is low. A refused push reports full, and a pop or query on an
// empty stack reports empty, with no change to the stack.
// The request is taken in the idle state, where the top entry is read from
// the memories into registers. The execute state applies the request and
// loads the result register, and the output state presents the result.
// in_stall stays high from acceptance until the result has been taken, so a
// stall at the output holds the result and holds off the next request.
// Reset clears the entry count, so the stack starts empty. The memories are
// not cleared; no entry is used before it has been written.
// ----------------------------------------------------------------------------
`default_nettype none

module min_tracking_stack
  import min_stk_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     req_type,
  input  logic [VALUE_WIDTH-1:0]         push_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [VALUE_WIDTH-1:0]         result_value,
  output logic [1:0]                     status,
  output logic [$clog2(DEPTH + 1)-1:0]   fill_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t cmd;

  min_stk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  min_stk_dp #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW),
    .CW          (CW)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req_type     (req_type),
    .push_value   (push_value),
    .result_value (result_value),
    .status       (status),
    .fill_count   (fill_count)
  );

`ifndef SYNTHESIS
  // An accepted request passes through the execute state and then presents its result.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> ##1 out_valid)
    else $error("result not presented two cycles after request");

  // Once a result is taken the block is ready for the next request.
  a_ready_after_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !in_stall && !out_valid)
    else $error("block not ready after result was taken");

  // The reported count never exceeds the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fill_count <= CW'(DEPTH)))
    else $error("fill count beyond depth");

  // A refused push only happens on a full stack.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_FULL)) |-> (fill_count == CW'(DEPTH)))
    else $error("full status with stack not full");
`endif

endmodule : min_tracking_stack

`default_nettype wire

// File: tb/min_tracking_stack_test.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_test
// Self-checking testbench for the minimum-tracking stack.
// ----------------------------------------------------------------------------
// Requests go in through a valid/stall handshake, and each result is checked
// against a predictor that keeps its own copy of the stack and of the running
// minimum at each level. Directed requests cover the empty and full stack,
// extreme values, equal minimums and the unused request code. Random
// sequences then sweep the stack depth under three idling profiles. One long
// hold-off at the output backs the block up while requests keep coming.
// ----------------------------------------------------------------------------
`default_nettype none

module min_tracking_stack_test;
  import min_stk_pkg::*;

  localparam int DEPTH          = DEPTH_DEF;
  localparam int VW             = VALUE_WIDTH_DEF;
  localparam int CW             = $clog2(DEPTH + 1);
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 8;

  // Request code that the block ignores.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [VW-1:0] value;
    logic [1:0]    stat;
    logic [CW-1:0] count;
  } stack_result_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [1:0]    req_type = REQ_PUSH;
  logic [VW-1:0] push_value = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [VW-1:0] result_value;
  logic [1:0]    status;
  logic [CW-1:0] fill_count;

  // Predictor state: pushed values and the running minimum at each level.
  logic signed [VW-1:0] model_values [DEPTH];
  logic signed [VW-1:0] model_mins [DEPTH];
  int                   model_depth = 0;

  stack_result_t pending_results[$];
  stack_result_t oldest_result;

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_request   = 0;
  int hold_left      = 0;

  min_tracking_stack u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .push_value   (push_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .status       (status),
    .fill_count   (fill_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic stack_result_t stack_predict(logic [1:0] req, logic signed [VW-1:0] val);
    stack_result_t        r;
    logic signed [VW-1:0] new_min;
    r.value = '0;
    r.stat  = ST_OK;
    case (req)
      REQ_PUSH: begin
        if (model_depth >= DEPTH) begin
          r.stat = ST_FULL;
        end else begin
          new_min = val;
          if (model_depth > 0 && model_mins[model_depth-1] < val) new_min = model_mins[model_depth-1];
          model_values[model_depth] = val;
          model_mins[model_depth]   = new_min;
          model_depth++;
        end
      end
      REQ_POP: begin
        if (model_depth == 0) begin
          r.stat = ST_EMPTY;
        end else begin
          model_depth--;
          r.value = model_values[model_depth];
        end
      end
      REQ_MIN: begin
        if (model_depth == 0) r.stat = ST_EMPTY;
        else r.value = model_mins[model_depth-1];
      end
      default: ;
    endcase
    r.count = CW'(model_depth);
    return r;
  endfunction

  // Extremes, a narrow band of small values so that equal minimums occur, and random values.
  function automatic logic [VW-1:0] pick_value();
    logic signed [VW-1:0] v;
    case ($urandom_range(9))
      0: v = {1'b0, {(VW-1){1'b1}}};
      1: v = {1'b1, {(VW-1){1'b0}}};
      2: v = '0;
      3: v = '1;
      4, 5: v = $signed(VW'($urandom_range(15))) - 8;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Offers one request, holds it until it is taken, then records the expected result.
  task automatic send_request(input logic [1:0] req, input logic [VW-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= req;
    push_value <= val;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(stack_predict(req, val));
  endtask

  function automatic void compare_field(string name, logic [VW-1:0] exp_v, logic [VW-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h/%0h/%0h",
                 $time, result_value, status, fill_count);
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        compare_field("result_value", oldest_result.value, result_value);
        compare_field("status", VW'(oldest_result.stat), VW'(status));
        compare_field("fill_count", VW'(oldest_result.count), VW'(fill_count));
      end
    end
  end

  // The receiver stalls at random, or for a whole stretch once one is asked for.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_empty_requests();
    send_request(REQ_POP, $urandom);
    send_request(REQ_MIN, $urandom);
    send_request(REQ_UNUSED, $urandom);
  endtask

  task automatic test_extremes();
    send_request(REQ_PUSH, {1'b0, {(VW-1){1'b1}}});
    send_request(REQ_MIN, $urandom);
    send_request(REQ_PUSH, {1'b1, {(VW-1){1'b0}}});
    send_request(REQ_MIN, $urandom);
    send_request(REQ_PUSH, '0);
    send_request(REQ_MIN, $urandom);
    send_request(REQ_UNUSED, '1);
    send_request(REQ_POP, $urandom);
    send_request(REQ_POP, $urandom);
    send_request(REQ_POP, $urandom);
    send_request(REQ_POP, $urandom);
  endtask

  task automatic test_equal_minimum();
    send_request(REQ_PUSH, -5);
    send_request(REQ_PUSH, -5);
    send_request(REQ_MIN, $urandom);
    send_request(REQ_POP, $urandom);
    send_request(REQ_MIN, $urandom);
    send_request(REQ_PUSH, 3);
    send_request(REQ_MIN, $urandom);
    send_request(REQ_POP, $urandom);
    send_request(REQ_POP, $urandom);
  endtask

  // Fills the stack, pushes against the full stack, then drains it past empty.
  task automatic test_full_stack();
    while (model_depth < DEPTH) send_request(REQ_PUSH, pick_value());
    send_request(REQ_PUSH, pick_value());
    send_request(REQ_MIN, $urandom);
    send_request(REQ_UNUSED, $urandom);
    send_request(REQ_PUSH, pick_value());
    while (model_depth > 0) begin
      if ($urandom_range(3) == 0) send_request(REQ_MIN, $urandom);
      send_request(REQ_POP, $urandom);
    end
    send_request(REQ_POP, $urandom);
  endtask

  // The output holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    int saved_idle;
    saved_idle    = send_idle_pct;
    send_idle_pct = 0;
    hold_request  = 200;
    repeat (20) send_request(($urandom_range(1) == 0) ? REQ_PUSH : REQ_MIN, pick_value());
    send_idle_pct = saved_idle;
  endtask

  // Runs of push-heavy, pop-heavy and balanced requests sweep the depth.
  task automatic test_random_mix(input int n_items);
    int         sent;
    int         push_w;
    int         pop_w;
    int         r;
    logic [1:0] req;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(2))
        0: begin
          push_w = 60;
          pop_w  = 20;
        end
        1: begin
          push_w = 20;
          pop_w  = 60;
        end
        default: begin
          push_w = 40;
          pop_w  = 35;
        end
      endcase
      repeat ($urandom_range(20, 60)) begin
        r = $urandom_range(99);
        if (r < 3) req = REQ_UNUSED;
        else if (r < 3 + push_w) req = REQ_PUSH;
        else if (r < 3 + push_w + pop_w) req = REQ_POP;
        else req = REQ_MIN;
        send_request(req, pick_value());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 32;
    recv_idle_pct = 76;
    test_empty_requests();
    test_extremes();
    test_equal_minimum();
    test_full_stack();
    test_random_mix(400);

    send_idle_pct = 76;
    recv_idle_pct = 32;
    test_backpressure();
    test_full_stack();
    test_random_mix(400);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_full_stack();
    test_random_mix(350);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: min_tracking_stack.f
sv/min_stk_pkg.sv
sv/min_stk_ctrl.sv
sv/min_stk_dp.sv
sv/min_tracking_stack.sv
tb/min_tracking_stack_test.sv
